/* sv/sbm_pkg.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// sbm_pkg
// Shared types and constants for the serially loaded bank mapper.
// -----------------------------------------------------------------------------
package sbm_pkg;

	localparam int unsigned SHIFT_W   = 5;
	localparam int unsigned COUNT_W   = 3;
	localparam int unsigned BANK_W    = 5;
	localparam int unsigned DATA_W    = 8;
	localparam int unsigned SEL_W     = 2;
	localparam int unsigned MAP_W     = 23;
	localparam int unsigned TDATA_W   = 24;

	localparam int unsigned RESET_BIT      = 7;
	localparam int unsigned CTRL_CHR4K_BIT = 4;
	localparam int unsigned CTRL_PRG16_BIT = 3;
	localparam int unsigned CTRL_SWLOW_BIT = 2;

	localparam logic [COUNT_W-1:0] LAST_BIT_COUNT = COUNT_W'(SHIFT_W - 1);
	localparam logic [BANK_W-1:0]  PRG_LOW_RST    = 5'd14;
	localparam logic [BANK_W-1:0]  PRG_HIGH_RST   = 5'd15;

	typedef enum logic [SEL_W-1:0] {
		SEL_CTRL = 2'd0,
		SEL_CHR0 = 2'd1,
		SEL_CHR1 = 2'd2,
		SEL_PRG  = 2'd3
	} sbm_sel_t;

	typedef struct packed {
		logic [BANK_W-1:0] prg_bank_high;
		logic [BANK_W-1:0] prg_bank_low;
		logic [BANK_W-1:0] chr_bank_second;
		logic [BANK_W-1:0] chr_bank_first;
		logic              chr_4k_mode;
		logic [1:0]        mirroring;
	} sbm_map_t;

endpackage
`default_nettype wire

/* sv/serial_loaded_bank_mapper_core.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// serial_loaded_bank_mapper_core
// Serially loaded bank mapper: one CPU write per beat in, one mapping report out.
// -----------------------------------------------------------------------------
// Each input beat is one mapper write (tuser = register select, tdata = byte)
// and yields exactly one output beat with the commit flag in tuser and the
// resulting mirroring, character and program banks in tdata. The block takes
// one beat per cycle while the output is not stalled; an accepted beat passes
// through the input register, then the shifter and bank update, into the
// output register. Backpressure on the output stalls the input after the
// input register fills.
module serial_loaded_bank_mapper_core import sbm_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_axis_tvalid,
	output logic                    s_axis_tready,
	input  wire logic [DATA_W-1:0]  s_axis_tdata,  // [7:0] write_data
	input  wire logic [SEL_W-1:0]   s_axis_tuser,  // [1:0] reg_select
	output logic                    m_axis_tvalid,
	input  wire logic               m_axis_tready,
	output logic [TDATA_W-1:0]      m_axis_tdata,  // [1:0] mirroring, [2] chr_4k_mode,
	                                               // [7:3] chr_bank_first,
	                                               // [12:8] chr_bank_second,
	                                               // [17:13] prg_bank_low,
	                                               // [22:18] prg_bank_high, [23] zero
	output logic                    m_axis_tuser   // [0] committed
);

	logic              valid_s1;
	sbm_sel_t          sel_s1;
	logic [DATA_W-1:0] data_s1;
	logic              advance;
	logic              committed;
	sbm_map_t          map_next;
	sbm_map_t          map_q;
	logic              committed_q;

	assign advance       = valid_s1 && (!m_axis_tvalid || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			sel_s1  <= sbm_sel_t'(s_axis_tuser);
			data_s1 <= s_axis_tdata;
		end
	end

	sbm_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.sel       (sel_s1),
		.data      (data_s1),
		.committed (committed),
		.map_next  (map_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (advance) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			map_q       <= map_next;
			committed_q <= committed;
		end
	end

	assign m_axis_tuser = committed_q;
	assign m_axis_tdata = {1'b0, map_q};

endmodule
`default_nettype wire

/* sv/sbm_regs.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// sbm_regs
// Serial shifter, mode flags and bank registers; yields the mapping after a beat.
// -----------------------------------------------------------------------------
module sbm_regs import sbm_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                step,
	input  wire sbm_sel_t            sel,
	input  wire logic [DATA_W-1:0]   data,
	output logic                     committed,
	output sbm_map_t                 map_next
);

	logic [SHIFT_W-1:0] shift_q;
	logic [COUNT_W-1:0] count_q;
	logic               chr4k_q;
	logic               prg16_q;
	logic               swlow_q;
	logic [1:0]         mirror_q;
	logic [BANK_W-1:0]  chr0_q;
	logic [BANK_W-1:0]  chr1_q;
	logic [BANK_W-1:0]  prg_lo_q;
	logic [BANK_W-1:0]  prg_hi_q;

	logic [SHIFT_W-1:0] shift_d;
	logic [COUNT_W-1:0] count_d;
	logic               chr4k_d;
	logic               prg16_d;
	logic               swlow_d;
	logic [1:0]         mirror_d;
	logic [BANK_W-1:0]  chr0_d;
	logic [BANK_W-1:0]  chr1_d;
	logic [BANK_W-1:0]  prg_lo_d;
	logic [BANK_W-1:0]  prg_hi_d;
	logic [BANK_W-1:0]  bank;
	logic               is_reset;
	logic               done;

	always_comb begin
		is_reset  = data[RESET_BIT];
		shift_d   = {data[0], shift_q[SHIFT_W-1:1]};
		done      = !is_reset && (count_q == LAST_BIT_COUNT);
		bank      = {1'b0, shift_d[3:0]};
		count_d   = count_q + 3'd1;
		chr4k_d   = chr4k_q;
		prg16_d   = prg16_q;
		swlow_d   = swlow_q;
		mirror_d  = mirror_q;
		chr0_d    = chr0_q;
		chr1_d    = chr1_q;
		prg_lo_d  = prg_lo_q;
		prg_hi_d  = prg_hi_q;
		if (is_reset) begin
			shift_d = '0;
			count_d = '0;
			chr4k_d = 1'b0;
			prg16_d = 1'b1;
			swlow_d = 1'b1;
		end else if (done) begin
			count_d = '0;
			case (sel)
				SEL_CTRL: begin
					chr4k_d  = shift_d[CTRL_CHR4K_BIT];
					prg16_d  = shift_d[CTRL_PRG16_BIT];
					swlow_d  = shift_d[CTRL_SWLOW_BIT];
					mirror_d = shift_d[1:0];
				end
				SEL_CHR0: chr0_d = shift_d;
				SEL_CHR1: begin
					if (chr4k_q) begin
						chr1_d = shift_d;
					end
				end
				SEL_PRG: begin
					if (!prg16_q) begin
						prg_lo_d = bank;
						prg_hi_d = bank + 5'd1;
					end else if (swlow_q) begin
						prg_lo_d = bank;
					end else begin
						prg_hi_d = bank;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q  <= '0;
			count_q  <= '0;
			chr4k_q  <= 1'b0;
			prg16_q  <= 1'b0;
			swlow_q  <= 1'b0;
			mirror_q <= '0;
			chr0_q   <= '0;
			chr1_q   <= '0;
			prg_lo_q <= PRG_LOW_RST;
			prg_hi_q <= PRG_HIGH_RST;
		end else if (step) begin
			shift_q  <= shift_d;
			count_q  <= count_d;
			chr4k_q  <= chr4k_d;
			prg16_q  <= prg16_d;
			swlow_q  <= swlow_d;
			mirror_q <= mirror_d;
			chr0_q   <= chr0_d;
			chr1_q   <= chr1_d;
			prg_lo_q <= prg_lo_d;
			prg_hi_q <= prg_hi_d;
		end
	end

	assign committed                = done;
	assign map_next.mirroring       = mirror_d;
	assign map_next.chr_4k_mode     = chr4k_d;
	assign map_next.chr_bank_first  = chr0_d;
	assign map_next.chr_bank_second = chr1_d;
	assign map_next.prg_bank_low    = prg_lo_d;
	assign map_next.prg_bank_high   = prg_hi_d;

endmodule
`default_nettype wire

/* sv/sbm_checker.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// sbm_port_checks
// Port-level checks for the bank mapper, bound to the top level.
// -----------------------------------------------------------------------------
module sbm_port_checks import sbm_pkg::*; (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               s_axis_tready,
	input wire logic               m_axis_tvalid,
	input wire logic               m_axis_tready,
	input wire logic [TDATA_W-1:0] m_axis_tdata,
	input wire logic               m_axis_tuser
);

	// stalled output beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("output beat changed while stalled");

	// program banks never exceed 16, pad bit zero
	a_prg_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !m_axis_tdata[23] &&
			(m_axis_tdata[17:13] <= 5'd16) && (m_axis_tdata[22:18] <= 5'd16))
		else $error("program bank out of range");

	// input only stalls when the output is stalled
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without output backpressure");

	a_reset_empty: assert property (@(posedge clk)
		!arst_n |-> !m_axis_tvalid)
		else $error("output valid during reset");

endmodule

bind serial_loaded_bank_mapper_core sbm_port_checks u_sbm_port_checks (.*);
`default_nettype wire

/* tb/sbm_checker.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// sbm_checker
// Watches both streams of the bank mapper, predicts every mapping report and
// compares it field by field with the beat the block sends back.
// -----------------------------------------------------------------------------
// Every accepted write runs through a local copy of the mapper state and its
// report is queued. Each output beat is checked against the oldest queued
// report. An output beat with nothing queued is a failure as well.
module sbm_checker import sbm_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	input  wire logic               s_tready,
	input  wire logic [DATA_W-1:0]  s_tdata,   // [7:0] write_data
	input  wire logic [SEL_W-1:0]   s_tuser,   // [1:0] reg_select
	input  wire logic               m_tvalid,
	input  wire logic               m_tready,
	input  wire logic [TDATA_W-1:0] m_tdata,   // [22:0] sbm_map_t, [23] zero
	input  wire logic               m_tuser,   // [0] committed
	output int                      fail_count,
	output int                      pending_reports,
	output int                      reports_checked,
	output int                      commits_seen
);

	typedef struct packed {
		logic     committed;
		sbm_map_t map;
	} map_report_t;

	map_report_t expected_reports[$];

	logic [SHIFT_W-1:0] shifter;
	logic [COUNT_W-1:0] bits_loaded;
	logic               chr_4k;
	logic               prg_16k;
	logic               prg_switch_low;
	logic [1:0]         mirror;
	logic [BANK_W-1:0]  chr_bank [2];
	logic [BANK_W-1:0]  prg_window [2];

	task automatic predict_write(input sbm_sel_t sel, input logic [DATA_W-1:0] data,
			output map_report_t rpt);
		logic [BANK_W-1:0] bank;
		rpt.committed = 1'b0;
		if (data[RESET_BIT]) begin
			shifter        = '0;
			bits_loaded    = '0;
			prg_16k        = 1'b1;
			prg_switch_low = 1'b1;
			chr_4k         = 1'b0;
		end else begin
			shifter     = {data[0], shifter[SHIFT_W-1:1]};
			bits_loaded = bits_loaded + 1'b1;
			if (bits_loaded == COUNT_W'(SHIFT_W)) begin
				bits_loaded   = '0;
				rpt.committed = 1'b1;
				case (sel)
					SEL_CTRL: begin
						chr_4k         = shifter[CTRL_CHR4K_BIT];
						prg_16k        = shifter[CTRL_PRG16_BIT];
						prg_switch_low = shifter[CTRL_SWLOW_BIT];
						mirror         = shifter[1:0];
					end
					SEL_CHR0: chr_bank[0] = shifter;
					SEL_CHR1: begin
						// ignored in 8k mode, still a commit
						if (chr_4k)
							chr_bank[1] = shifter;
					end
					default: begin
						bank = {1'b0, shifter[3:0]};
						if (!prg_16k) begin
							prg_window[0] = bank;
							prg_window[1] = bank + 1'b1;
						end else if (prg_switch_low) begin
							prg_window[0] = bank;
						end else begin
							prg_window[1] = bank;
						end
					end
				endcase
			end
		end
		rpt.map.mirroring       = mirror;
		rpt.map.chr_4k_mode     = chr_4k;
		rpt.map.chr_bank_first  = chr_bank[0];
		rpt.map.chr_bank_second = chr_bank[1];
		rpt.map.prg_bank_low    = prg_window[0];
		rpt.map.prg_bank_high   = prg_window[1];
	endtask

	function automatic int field_mismatch(string name, int expv, int act);
		if (expv != act) begin
			$error("%s: expected %0d, actual %0d", name, expv, act);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		map_report_t want;
		map_report_t rpt;
		sbm_map_t    got;
		int          errs;
		if (!arst_n) begin
			shifter         = '0;
			bits_loaded     = '0;
			chr_4k          = 1'b0;
			prg_16k         = 1'b0;
			prg_switch_low  = 1'b0;
			mirror          = 2'd0;
			chr_bank[0]     = '0;
			chr_bank[1]     = '0;
			prg_window[0]   = PRG_LOW_RST;
			prg_window[1]   = PRG_HIGH_RST;
			expected_reports.delete();
			fail_count      = 0;
			pending_reports = 0;
			reports_checked = 0;
			commits_seen    = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_reports.size() == 0) begin
					$error("mapping report beat with no write pending");
					fail_count++;
				end else begin
					want = expected_reports.pop_front();
					got  = sbm_map_t'(m_tdata[MAP_W-1:0]);
					errs = 0;
					errs += field_mismatch("committed", want.committed, m_tuser);
					errs += field_mismatch("mirroring", want.map.mirroring, got.mirroring);
					errs += field_mismatch("chr_4k_mode", want.map.chr_4k_mode,
						got.chr_4k_mode);
					errs += field_mismatch("chr_bank_first", want.map.chr_bank_first,
						got.chr_bank_first);
					errs += field_mismatch("chr_bank_second", want.map.chr_bank_second,
						got.chr_bank_second);
					errs += field_mismatch("prg_bank_low", want.map.prg_bank_low,
						got.prg_bank_low);
					errs += field_mismatch("prg_bank_high", want.map.prg_bank_high,
						got.prg_bank_high);
					errs += field_mismatch("tdata pad", 0, m_tdata[TDATA_W-1]);
					fail_count += errs;
					reports_checked++;
					if (m_tuser)
						commits_seen++;
				end
			end
			if (s_tvalid && s_tready) begin
				predict_write(sbm_sel_t'(s_tuser), s_tdata, rpt);
				expected_reports.push_back(rpt);
			end
			pending_reports = expected_reports.size();
		end
	end

endmodule
`default_nettype wire

/* tb/tb_top.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// tb_top
// Stream-level test of the serially loaded bank mapper core.
// -----------------------------------------------------------------------------
// Drives mapper writes (directed corner loads, then random five-bit loads,
// reset bytes and stray writes) in three idling phases, with a long output
// stall in phases 1 and 3, a full drain after each. The checker predicts and
// compares every report; this module builds stimulus and gives the verdict.
module tb_top;
	import sbm_pkg::*;

	localparam int LONG_STALL   = 300;
	localparam int DRAIN_CYCLES = 10;
	localparam int PHASE_WRITES = 375;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [DATA_W-1:0]  s_tdata;
	logic [SEL_W-1:0]   s_tuser;
	logic               m_tvalid;
	logic               m_tready;
	logic [TDATA_W-1:0] m_tdata;
	logic               m_tuser;

	int fail_count;
	int pending_reports;
	int reports_checked;
	int commits_seen;
	int writes_sent;
	int send_idle_pct;
	int recv_idle_pct;
	int stall_requests;

	always #5 clk = ~clk;

	serial_loaded_bank_mapper_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_tready),
		.s_axis_tdata  (s_tdata),
		.s_axis_tuser  (s_tuser),
		.m_axis_tvalid (m_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_tdata),
		.m_axis_tuser  (m_tuser)
	);

	sbm_checker u_chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tuser         (s_tuser),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.m_tuser         (m_tuser),
		.fail_count      (fail_count),
		.pending_reports (pending_reports),
		.reports_checked (reports_checked),
		.commits_seen    (commits_seen)
	);

	task automatic send_write(input sbm_sel_t sel, input logic [DATA_W-1:0] data);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= data;
		s_tuser  <= sel;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		writes_sent++;
	endtask

	// five serial beats, LSB first; select of the earlier beats is don't-care
	task automatic load_register(input sbm_sel_t target, input logic [SHIFT_W-1:0] value);
		sbm_sel_t sel;
		logic [5:0] junk;
		for (int i = 0; i < SHIFT_W; i++) begin
			sel  = (i == SHIFT_W - 1) ? target : sbm_sel_t'($urandom_range(3));
			junk = 6'($urandom);
			send_write(sel, {1'b0, junk, value[i]});
		end
	endtask

	task automatic run_random(input int count);
		int stop_at;
		int pick;
		stop_at = writes_sent + count;
		while (writes_sent < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 72)
				load_register(sbm_sel_t'($urandom_range(3)), 5'($urandom));
			else if (pick < 84)
				send_write(sbm_sel_t'($urandom_range(3)), {1'b1, 7'($urandom)});
			else
				send_write(sbm_sel_t'($urandom_range(3)), 8'($urandom));
		end
	endtask

	task automatic drain_reports();
		@(negedge clk);
		s_tvalid <= 1'b0;
		wait (pending_reports == 0);
	endtask

	// output side: random backpressure, plus long stalls on request
	initial begin
		int stalls_done;
		stalls_done = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_requests != stalls_done) begin
				stalls_done++;
				m_tready <= 1'b0;
				repeat (LONG_STALL - 1) @(negedge clk);
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	initial begin
		#2_000_000;
		$display("timeout with %0d reports still pending", pending_reports);
		$display("FAILURE");
		$finish;
	end

	initial begin
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		s_tuser        = SEL_CTRL;
		writes_sent    = 0;
		stall_requests = 0;
		send_idle_pct  = 28;
		recv_idle_pct  = 56;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// 32k mode from reset: top bank lands in the low window, one past it high
		load_register(SEL_PRG, 5'h0F);
		send_write(SEL_CTRL, 8'hFF);
		// 4k chr, 16k prg switching low window, horizontal mirroring
		load_register(SEL_CTRL, 5'h1F);
		load_register(SEL_CHR1, 5'h1F);
		// reset byte in the middle of a load
		send_write(SEL_CHR0, 8'h7F);
		send_write(SEL_CHR1, 8'h00);
		send_write(SEL_PRG, 8'h01);
		send_write(SEL_PRG, 8'h80);
		// back in 8k mode: second chr bank write is dropped
		load_register(SEL_CHR1, 5'h0A);

		run_random(180);
		stall_requests++;
		run_random(PHASE_WRITES - 180);
		drain_reports();

		send_idle_pct = 56;
		recv_idle_pct = 28;
		run_random(PHASE_WRITES);
		drain_reports();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		stall_requests++;
		run_random(PHASE_WRITES);

		@(negedge clk);
		s_tvalid <= 1'b0;
		wait (pending_reports == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run covered %0d mapper writes, %0d reports checked, %0d register commits",
			writes_sent, reports_checked, commits_seen);
		$display("three idling phases, two long output stalls, %0d mismatches", fail_count);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
`default_nettype wire

/* sim.f */
sv/sbm_pkg.sv
sv/sbm_regs.sv
sv/serial_loaded_bank_mapper_core.sv
sv/sbm_checker.sv
tb/sbm_checker.sv
tb/tb_top.sv
